// ----- rtl/core/hng_pkg.sv -----
package hng_pkg;

   // default line buffer capacity (segments per side)
   localparam int MAX_GRID_DEF = 256;

   localparam int HEIGHT_W   = 16;
   localparam int DIFF_W     = HEIGHT_W + 1;
   localparam int POS_W      = 9;
   localparam int GRID_W     = 9;
   localparam int SLOPE_W    = 16;
   localparam int CSR_DATA_W = 16;

   localparam logic [GRID_W-1:0]  GRID_RESET  = 9'd64;
   localparam logic [SLOPE_W-1:0] SLOPE_RESET = 16'd512;

   localparam int SQRT_STEPS = 21;
   localparam int DIV_STEPS  = 16;

   typedef enum logic {
      CSR_GRID_SIZE   = 1'b0,
      CSR_SLOPE_SCALE = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_RD,
      F_RD2,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      C_IDLE,
      C_MUL,
      C_SCALE,
      C_SQ,
      C_SUM,
      C_SQRT,
      C_DLOAD,
      C_DIV,
      C_DSTORE,
      C_OUT
   } calc_state_type;

   typedef enum logic [1:0] {
      SEL_X,
      SEL_Y,
      SEL_Z
   } div_sel_type;

   // one normal to compute: neighbor differences and vertex position
   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic [POS_W-1:0]         col;
      logic [POS_W-1:0]         row;
      logic                     last;
   } hng_job_type;

endpackage

// ----- rtl/core/hng_req_if.sv -----
interface hng_req_if import hng_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       func;
   logic signed [HEIGHT_W-1:0] height;

   modport source (output valid, func, height, input ready);
   modport sink   (input valid, func, height, output ready);
endinterface

// ----- rtl/core/hng_rsp_if.sv -----
interface hng_rsp_if import hng_pkg::*; ();
   logic               valid;
   logic               ready;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [14:0] normal_z;
   logic [POS_W-1:0]   vertex_col;
   logic [POS_W-1:0]   vertex_row;
   logic               last_normal;

   modport source (output valid, normal_x, normal_y, normal_z, vertex_col, vertex_row,
                   last_normal, input ready);
   modport sink   (input valid, normal_x, normal_y, normal_z, vertex_col, vertex_row,
                   last_normal, output ready);
endinterface

// ----- rtl/core/hng_front.sv -----
module hng_front import hng_pkg::*; #(
   parameter int MAX_GRID = MAX_GRID_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [GRID_W-1:0] grid_size,
   hng_req_if.sink           req,
   output logic              push_valid,
   input  logic              push_ready,
   output hng_job_type       push_job
);

   localparam int CW = $clog2(MAX_GRID + 2);
   localparam int AW = $clog2(MAX_GRID + 1);

   front_state_type state_ff, state_in;
   logic [CW-1:0] col_ff, row_ff, drain_ff, pos_ff, outrow_ff;
   logic [CW-1:0] g, cs, ds;
   logic [31:0]   gs32;
   logic          drain_phase, take_sample, take_drain, need_rd, accept;
   logic          isdr_ff, upv_ff, hasl_ff, hasr_ff, last_ff;
   logic signed [HEIGHT_W-1:0] h_ff, ctr_ff, rgt_ff, uph_ff;
   logic signed [HEIGHT_W-1:0] ctr, upv, rgt, lft;
   hng_job_type job_ff;

   // line buffers
   logic signed [HEIGHT_W-1:0] mid_mem [0:MAX_GRID];
   logic signed [HEIGHT_W-1:0] up_mem  [0:MAX_GRID];
   logic signed [HEIGHT_W-1:0] mid_q0, mid_q1, up_q0, up_q1, mid_wd;
   logic [AW-1:0] m0_a, m1_a, u0_a, u1_a, mid_wa;
   logic          mid_we, up_we;

   // effective grid size
   assign gs32 = 32'(grid_size);
   always_comb begin
      if (gs32 == 32'd0) begin
         g = CW'(1);
      end else if (gs32 > 32'(MAX_GRID)) begin
         g = CW'(MAX_GRID);
      end else begin
         g = CW'(gs32);
      end
   end

   assign cs          = (col_ff > g) ? g : col_ff;
   assign ds          = (drain_ff > g) ? g : drain_ff;
   assign drain_phase = row_ff > g;
   assign accept      = req.valid && req.ready;
   assign take_sample = accept && !req.func && !drain_phase;
   assign take_drain  = accept && req.func && drain_phase;
   assign need_rd     = take_drain || (take_sample && row_ff != '0);

   // read addresses
   always_comb begin
      m0_a = AW'(pos_ff);
      m1_a = AW'(pos_ff);
      u0_a = AW'(pos_ff);
      u1_a = AW'(pos_ff);
      if (state_ff == F_IDLE) begin
         if (req.func) begin
            m0_a = AW'(ds);
            m1_a = (ds < g) ? AW'(ds + 1'b1) : AW'(ds);
            u0_a = AW'(ds);
         end else begin
            m0_a = AW'(cs);
            m1_a = (cs < g) ? AW'(cs + 1'b1) : AW'(cs);
            u0_a = AW'(cs);
            u1_a = (cs != '0) ? AW'(cs - 1'b1) : AW'(cs);
         end
      end else if (state_ff == F_RD) begin
         m1_a = (pos_ff != '0) ? AW'(pos_ff - 1'b1) : AW'(pos_ff);
      end
   end

   // write ports
   assign mid_we = (take_sample && row_ff == '0) || (state_ff == F_RD && !isdr_ff);
   assign mid_wa = (state_ff == F_IDLE) ? AW'(cs) : AW'(pos_ff);
   assign mid_wd = (state_ff == F_IDLE) ? req.height : h_ff;
   assign up_we  = (state_ff == F_RD) && !isdr_ff;

   always_ff @(posedge clock) begin
      if (mid_we) begin
         mid_mem[mid_wa] <= mid_wd;
      end
      mid_q0 <= mid_mem[m0_a];
      mid_q1 <= mid_mem[m1_a];
   end

   always_ff @(posedge clock) begin
      if (up_we) begin
         up_mem[AW'(pos_ff)] <= mid_q0;
      end
      up_q0 <= up_mem[u0_a];
      up_q1 <= up_mem[u1_a];
   end

   // neighbor selection for a sample beat
   assign ctr = mid_q0;
   assign upv = upv_ff ? up_q0 : ctr;
   assign rgt = hasr_ff ? mid_q1 : ctr;
   assign lft = hasl_ff ? up_q1 : ctr;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (need_rd) state_in = F_RD;
         end
         F_RD:   state_in = isdr_ff ? F_RD2 : F_PUSH;
         F_RD2:  state_in = F_PUSH;
         F_PUSH: begin
            if (push_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req.ready  = (state_ff == F_IDLE);
      push_valid = (state_ff == F_PUSH);
      push_job   = job_ff;
   end

   // control and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (take_sample) begin
            if (cs >= g) begin
               col_ff   <= '0;
               row_ff   <= row_ff + 1'b1;
               drain_ff <= '0;
            end else begin
               col_ff <= cs + 1'b1;
            end
         end
         if (take_drain) begin
            if (ds >= g) begin
               col_ff   <= '0;
               row_ff   <= '0;
               drain_ff <= '0;
            end else begin
               drain_ff <= ds + 1'b1;
            end
         end
      end
   end

   // item context and job assembly
   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff    <= req.func ? ds : cs;
         h_ff      <= req.height;
         isdr_ff   <= req.func;
         upv_ff    <= row_ff > CW'(1);
         hasl_ff   <= (req.func ? ds : cs) != '0;
         hasr_ff   <= (req.func ? ds : cs) < g;
         outrow_ff <= req.func ? g : row_ff - 1'b1;
         last_ff   <= req.func && (ds >= g);
      end
      if (state_ff == F_RD) begin
         if (isdr_ff) begin
            ctr_ff <= mid_q0;
            rgt_ff <= hasr_ff ? mid_q1 : mid_q0;
            uph_ff <= up_q0;
         end else begin
            job_ff.dx   <= {rgt[HEIGHT_W-1], rgt} - {lft[HEIGHT_W-1], lft};
            job_ff.dy   <= {h_ff[HEIGHT_W-1], h_ff} - {upv[HEIGHT_W-1], upv};
            job_ff.col  <= POS_W'(pos_ff);
            job_ff.row  <= POS_W'(outrow_ff);
            job_ff.last <= 1'b0;
         end
      end
      if (state_ff == F_RD2) begin
         job_ff.dx <= {rgt_ff[HEIGHT_W-1], rgt_ff}
                    - (hasl_ff ? {mid_q1[HEIGHT_W-1], mid_q1} : {ctr_ff[HEIGHT_W-1], ctr_ff});
         job_ff.dy   <= {ctr_ff[HEIGHT_W-1], ctr_ff} - {uph_ff[HEIGHT_W-1], uph_ff};
         job_ff.col  <= POS_W'(pos_ff);
         job_ff.row  <= POS_W'(outrow_ff);
         job_ff.last <= last_ff;
      end
   end

endmodule

// ----- rtl/core/hng_queue.sv -----
module hng_queue import hng_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  hng_job_type push_job,
   output logic        pop_valid,
   input  logic        pop_ready,
   output hng_job_type pop_job
);

   hng_job_type slot_ff [0:1];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_job    = slot_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) wptr_ff <= !wptr_ff;
         if (do_pop)  rptr_ff <= !rptr_ff;
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_job;
      end
   end

endmodule

// ----- rtl/core/hng_calc.sv -----
module hng_calc import hng_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [SLOPE_W-1:0] slope_scale,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  hng_job_type        pop_job,
   hng_rsp_if.source          rsp
);

   calc_state_type state_ff, state_in;
   div_sel_type    sel_ff;
   hng_job_type    job_ff;
   logic [4:0]     step_ff;

   logic signed [33:0] px_ff, py_ff;
   logic [33:0] pxm, pym;
   logic [19:0] amag_ff, bmag_ff;
   logic        asg_ff, bsg_ff;
   logic [39:0] aa_ff, bb_ff;
   logic [41:0] v_ff, res_ff, bit_ff, trial;
   logic [20:0] len;
   logic [34:0] mag;
   logic [37:0] rem_ff, dsh_ff;
   logic [15:0] q_ff;
   logic [15:0] nx_ff, ny_ff;
   logic [14:0] nz_ff;
   logic        sqrt_done, div_done;

   assign len       = res_ff[20:0];
   assign trial     = res_ff + bit_ff;
   assign sqrt_done = (step_ff == 5'(SQRT_STEPS - 1));
   assign div_done  = (step_ff == 5'(DIV_STEPS - 1));
   assign pxm       = px_ff[33] ? 34'(-px_ff) : 34'(px_ff);
   assign pym       = py_ff[33] ? 34'(-py_ff) : 34'(py_ff);

   // dividend magnitude of the current component
   always_comb begin
      case (sel_ff)
         SEL_X:   mag = {1'b0, amag_ff, 14'd0};
         SEL_Y:   mag = {1'b0, bmag_ff, 14'd0};
         default: mag = 35'd1 << 30;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         C_IDLE: begin
            if (pop_valid) state_in = C_MUL;
         end
         C_MUL:   state_in = C_SCALE;
         C_SCALE: state_in = C_SQ;
         C_SQ:    state_in = C_SUM;
         C_SUM:   state_in = C_SQRT;
         C_SQRT: begin
            if (sqrt_done) state_in = C_DLOAD;
         end
         C_DLOAD: state_in = C_DIV;
         C_DIV: begin
            if (div_done) state_in = C_DSTORE;
         end
         C_DSTORE: state_in = (sel_ff == SEL_Z) ? C_OUT : C_DLOAD;
         C_OUT: begin
            if (rsp.ready) state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop_ready        = (state_ff == C_IDLE);
      rsp.valid        = (state_ff == C_OUT);
      rsp.normal_x     = nx_ff;
      rsp.normal_y     = ny_ff;
      rsp.normal_z     = nz_ff;
      rsp.vertex_col   = job_ff.col;
      rsp.vertex_row   = job_ff.row;
      rsp.last_normal  = job_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath: scale, square, root, three rounded divisions
   always_ff @(posedge clock) begin
      case (state_ff)
         C_IDLE: begin
            if (pop_valid) job_ff <= pop_job;
         end
         C_MUL: begin
            px_ff <= 34'(job_ff.dx) * 34'($signed({1'b0, slope_scale}));
            py_ff <= 34'(job_ff.dy) * 34'($signed({1'b0, slope_scale}));
         end
         C_SCALE: begin
            amag_ff <= 20'((pxm + 34'd2048) >> 12);
            bmag_ff <= 20'((pym + 34'd2048) >> 12);
            asg_ff  <= px_ff[33];
            bsg_ff  <= py_ff[33];
         end
         C_SQ: begin
            aa_ff <= amag_ff * amag_ff;
            bb_ff <= bmag_ff * bmag_ff;
         end
         C_SUM: begin
            v_ff    <= 42'(aa_ff) + 42'(bb_ff) + (42'd1 << 32);
            res_ff  <= '0;
            bit_ff  <= 42'd1 << 40;
            step_ff <= '0;
            sel_ff  <= SEL_X;
         end
         C_SQRT: begin
            if (v_ff >= trial) begin
               v_ff   <= v_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff  <= bit_ff >> 2;
            step_ff <= step_ff + 1'b1;
         end
         C_DLOAD: begin
            rem_ff  <= 38'({mag, 1'b0}) + 38'(len);
            dsh_ff  <= 38'({len, 1'b0}) << 15;
            q_ff    <= '0;
            step_ff <= '0;
         end
         C_DIV: begin
            if (rem_ff >= dsh_ff) begin
               rem_ff <= rem_ff - dsh_ff;
               q_ff   <= {q_ff[14:0], 1'b1};
            end else begin
               q_ff   <= {q_ff[14:0], 1'b0};
            end
            dsh_ff  <= dsh_ff >> 1;
            step_ff <= step_ff + 1'b1;
         end
         C_DSTORE: begin
            case (sel_ff)
               SEL_X: begin
                  nx_ff  <= asg_ff ? 16'(-q_ff) : q_ff;
                  sel_ff <= SEL_Y;
               end
               SEL_Y: begin
                  ny_ff  <= bsg_ff ? 16'(-q_ff) : q_ff;
                  sel_ff <= SEL_Z;
               end
               default: begin
                  nz_ff  <= 15'(-q_ff);
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // root stays within its step count
   assert property (@(posedge clock) disable iff (reset)
      state_ff == C_SQRT |-> step_ff < 5'(SQRT_STEPS))
      else $error("root step count overrun");

   // length is at least one in Q.16 once the root is done
   assert property (@(posedge clock) disable iff (reset)
      state_ff == C_DLOAD |-> len >= 21'd65536)
      else $error("vector length below unity");

   // z component never positive
   assert property (@(posedge clock) disable iff (reset)
      state_ff == C_OUT |-> (nz_ff[14] || nz_ff == 15'd0))
      else $error("positive z component");

   // a job is taken only when the unit is free
   assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |=> state_ff == C_MUL)
      else $error("job taken while busy");

endmodule

// ----- rtl/core/heightmap_normal_generator_core.sv -----
// Heightmap normal generator, central differences over a raster stream.
// req_chan: one beat per height sample (func 0) in raster order, or one
// drain beat (func 1) per last-row normal once all samples are in. Beats
// that do not fit the current phase are taken and dropped.
// rsp_chan: one beat per normal, with its vertex column and row; the final
// normal of the grid carries last_normal.
// csr_*: grid_size (index 0) and slope_scale (index 1); write only while idle.
// Throughput: the front takes a beat every cycle for first-row samples and
// dropped beats; for other samples and drains it holds ready low until
// its push is taken. The back takes a new normal only once the last is
// accepted, its run set by the bit-serial square root (21 steps) and the
// divider run three times (16 steps each).
// A two-entry queue between them lets the front run ahead.
// Reset: counts clear and config returns to grid 64, slope 512; line buffer
// contents stay undefined until written by the first rows.
// When rsp_chan stalls, the result holds in its output register, the queue
// fills, and then req_chan.ready drops.
module heightmap_normal_generator_core import hng_pkg::*; #(
   parameter int MAX_GRID = MAX_GRID_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   hng_req_if.sink               req_chan,
   hng_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [GRID_W-1:0]  grid_ff;
   logic [SLOPE_W-1:0] slope_ff;
   logic        push_valid, push_ready, pop_valid, pop_ready;
   hng_job_type push_job, pop_job;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff  <= GRID_RESET;
         slope_ff <= SLOPE_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_GRID_SIZE:   grid_ff  <= csr_wdata[GRID_W-1:0];
            CSR_SLOPE_SCALE: slope_ff <= csr_wdata[SLOPE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   hng_front #(.MAX_GRID(MAX_GRID)) u_front (
      .clock      (clock),
      .reset      (reset),
      .grid_size  (grid_ff),
      .req        (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   hng_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   hng_calc u_calc (
      .clock       (clock),
      .reset       (reset),
      .slope_scale (slope_ff),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_job     (pop_job),
      .rsp         (rsp_chan)
   );

endmodule
